// File: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: rtl/core/rsnl_pkg.sv
// Shared types, constants and commands for the record sort and lookup core
package rsnl_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int SURNAME_BYTES = 15;
   localparam int GIVEN_BYTES   = 10;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;

   localparam logic [63:0] SL_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> ((SURNAME_BYTES - 7) * 8));
   localparam logic [63:0] GL_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> ((GIVEN_BYTES - 2) * 8));

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_SORT = 2'd1,
      KIND_FIND_SN = 2'd2,
      KIND_FIND_GN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_SORT_DONE = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SORT_RD_I, S_SORT_RD_J, S_SORT_CMP, S_SORT_WR_J,
      S_FIND_RD, S_FIND_CHK, S_DONE, S_SORT_END
   } state_type;

   typedef struct packed {
      logic [55:0] sh;
      logic [63:0] sl;
      logic [15:0] gh;
      logic [63:0] gl;
      logic [31:0] sal;
   } rec_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;       // write request record at count
      logic             latch_req;  // capture request key
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             hold_i;     // capture read data as record i
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             wr_sel_i;   // 1: write record i, 0: write read record j
      logic             set_i_from_j; // record i takes read record j
      logic             resp;       // emit result
      logic [1:0]       resp_status;
      logic             resp_rec;   // result carries read record
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             gt;    // rec_i > read record
      logic             hit;   // read record matches key
   } dp_sts_type;

endpackage

// File: rtl/core/rsnl_datapath.sv
// Record table memory, key compare and result registers
module rsnl_datapath
   import rsnl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_sts_type       sts,
   input  logic [1:0]       req_kind,
   input  logic [55:0]      req_surname_high,
   input  logic [63:0]      req_surname_low,
   input  logic [15:0]      req_given_high,
   input  logic [63:0]      req_given_low,
   input  logic [31:0]      req_salary_in,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [55:0]      rsp_found_surname_high,
   output logic [63:0]      rsp_found_surname_low,
   output logic [15:0]      rsp_found_given_high,
   output logic [63:0]      rsp_found_given_low,
   output logic [31:0]      rsp_salary_out
);

   rec_type          mem [TABLE_DEPTH];
   rec_type          rd_ff;
   rec_type          rec_i_ff, rec_i_in;
   rec_type          key_ff;
   logic             by_sn_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   rec_type          req_rec;
   rec_type          wr_data;
   rec_type          out_ff, out_in;
   logic [1:0]       stat_ff;
   logic             valid_ff;

   assign req_rec = '{sh: req_surname_high, sl: req_surname_low & SL_MASK,
                      gh: req_given_high, gl: req_given_low & GL_MASK,
                      sal: req_salary_in};

   always_comb begin
      wr_data = cmd.wr_sel_i ? rec_i_ff : rd_ff;
      if (cmd.load) wr_data = req_rec;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) mem[count_ff[IDX_W-1:0]] <= wr_data;
      else if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
   end

   always_comb begin
      rec_i_in = rec_i_ff;
      if (cmd.hold_i) rec_i_in = rd_ff;
      else if (cmd.set_i_from_j) rec_i_in = rd_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) count_in = count_ff + 1'b1;
   end

   always_comb begin
      out_in = '0;
      if (cmd.resp_rec) out_in = rd_ff;
   end

   always_ff @(posedge clock) begin
      rec_i_ff <= rec_i_in;
      if (cmd.latch_req) begin
         key_ff   <= req_rec;
         by_sn_ff <= (req_kind == KIND_FIND_SN);
      end
      if (cmd.resp) begin
         out_ff  <= out_in;
         stat_ff <= cmd.resp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.resp;
      end
   end

   assign sts.count = count_ff;
   assign sts.gt    = {rec_i_ff.sh, rec_i_ff.sl, rec_i_ff.gh, rec_i_ff.gl} >
                      {rd_ff.sh, rd_ff.sl, rd_ff.gh, rd_ff.gl};
   assign sts.hit   = by_sn_ff ? (rd_ff.sh == key_ff.sh && rd_ff.sl == key_ff.sl)
                               : (rd_ff.gh == key_ff.gh && rd_ff.gl == key_ff.gl);

   assign rsp_valid              = valid_ff;
   assign rsp_status             = stat_ff;
   assign rsp_found_surname_high = out_ff.sh;
   assign rsp_found_surname_low  = out_ff.sl;
   assign rsp_found_given_high   = out_ff.gh;
   assign rsp_found_given_low    = out_ff.gl;
   assign rsp_salary_out         = out_ff.sal;

endmodule

// File: rtl/core/rsnl_ctrl.sv
// Sequencer for load, exchange sort and linear search
module rsnl_ctrl
   import rsnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_kind,
   output logic       busy,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             go;

   assign go = start && !busy;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               i_in = '0;
               j_in = '0;
               unique case (req_kind)
                  KIND_LOAD: state_in = S_IDLE;
                  KIND_SORT: state_in = S_SORT_RD_I;
                  default:   state_in = S_FIND_RD;
               endcase
            end
         end
         S_SORT_RD_I: begin
            j_in = i_ff + 1'b1;
            if (i_ff + 1'b1 >= sts.count) state_in = S_SORT_END;
            else state_in = S_SORT_RD_J;
         end
         S_SORT_RD_J: state_in = S_SORT_CMP;
         S_SORT_CMP: begin
            if (sts.gt) state_in = S_SORT_WR_J;
            else if (j_ff + 1'b1 < sts.count) begin
               j_in = j_ff + 1'b1;
               state_in = S_SORT_RD_J;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SORT_RD_I;
            end
         end
         S_SORT_WR_J: begin
            if (j_ff + 1'b1 < sts.count) begin
               j_in = j_ff + 1'b1;
               state_in = S_SORT_RD_J;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SORT_RD_I;
            end
         end
         S_FIND_RD: begin
            if (i_ff >= sts.count) state_in = S_DONE;
            else state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (sts.hit) state_in = S_IDLE;
            else begin
               i_in = i_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_DONE:     state_in = S_IDLE;
         S_SORT_END: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = go && (req_kind == KIND_LOAD) &&
                       (sts.count < CNT_W'(TABLE_DEPTH));
            cmd.latch_req = go;
         end
         S_SORT_RD_I: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff[IDX_W-1:0];
         end
         S_SORT_RD_J: begin
            // first visit of this i: read data is record i
            cmd.hold_i  = (j_ff == i_ff + 1'b1);
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff[IDX_W-1:0];
         end
         S_SORT_CMP: begin
            // swap: write old i at j; the next state writes old j at i and loads it into i
            cmd.wr_en    = sts.gt;
            cmd.wr_addr  = j_ff[IDX_W-1:0];
            cmd.wr_sel_i = 1'b1;
         end
         S_SORT_WR_J: begin
            cmd.set_i_from_j = 1'b1;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff[IDX_W-1:0];
         end
         S_FIND_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff[IDX_W-1:0];
         end
         S_FIND_CHK: begin
            cmd.resp        = sts.hit;
            cmd.resp_status = ST_FOUND;
            cmd.resp_rec    = 1'b1;
         end
         S_DONE: begin
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_NOT_FOUND;
         end
         S_SORT_END: begin
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_SORT_DONE;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

endmodule

// File: rtl/core/record_sort_and_name_lookup_core.sv
// Record table core: load, exchange sort, first-match lookup by name
// Load: no result. Lookup: one registered table read per entry, from index 0 up to the
// first match, or over all entries when not found.
// Sort of n records: one extra write step per swap, one read port per step.
// Synchronous active-high reset empties the table; results are one-cycle strobes
// that the receiver cannot stall.
`include "assert_macros.svh"
module record_sort_and_name_lookup_core
   import rsnl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [55:0] req_surname_high,
   input  logic [63:0] req_surname_low,
   input  logic [15:0] req_given_high,
   input  logic [63:0] req_given_low,
   input  logic [31:0] req_salary_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [55:0] rsp_found_surname_high,
   output logic [63:0] rsp_found_surname_low,
   output logic [15:0] rsp_found_given_high,
   output logic [63:0] rsp_found_given_low,
   output logic [31:0] rsp_salary_out
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   rsnl_ctrl u_ctrl (
      .clock, .reset, .start, .req_kind, .busy, .sts, .cmd
   );

   rsnl_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_kind, .req_surname_high, .req_surname_low,
      .req_given_high, .req_given_low, .req_salary_in, .rsp_valid, .rsp_status,
      .rsp_found_surname_high, .rsp_found_surname_low, .rsp_found_given_high,
      .rsp_found_given_low, .rsp_salary_out
   );

   `CHK_IMPLY(a_cnt_max, clock, reset, 1'b1, sts.count <= CNT_W'(TABLE_DEPTH),
      "record count above table depth")
   `CHK_NEXT(a_load_cnt, clock, reset, cmd.load, sts.count == $past(sts.count) + 1'b1,
      "load did not advance count")
   `CHK_IMPLY(a_rsp_busy, clock, reset, rsp_valid, !$past(reset),
      "result right after reset")

endmodule
